// ----- design/clex_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package clex_pkg;

    // Longest expression, in characters; positions saturate at the smaller of this and 65535
    localparam int unsigned MAX_LEN   = 65535;
    localparam logic [15:0] POS_LIMIT = 16'((MAX_LEN < 65535) ? MAX_LEN : 65535);

    // Token queue between the front and back parts
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [3:0] {
        K_LPAREN = 4'd0,
        K_RPAREN = 4'd1,
        K_PLUS   = 4'd2,
        K_MINUS  = 4'd3,
        K_STAR   = 4'd4,
        K_SLASH  = 4'd5,
        K_QUOTE  = 4'd6,
        K_CARET  = 4'd7,
        K_X      = 4'd8,
        K_VAR    = 4'd9,
        K_NUM    = 4'd10,
        K_BAD    = 4'd11,
        K_DOT    = 4'd12,
        K_LONG   = 4'd13
    } kind_t;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_VAR  = 4'b0010,
        MODE_NUM  = 4'b0100,
        MODE_DOT  = 4'b1000
    } mode_t;

    typedef enum logic [2:0] {
        CC_SPACE  = 3'd0,
        CC_SINGLE = 3'd1,
        CC_ALPHA  = 3'd2,
        CC_DIGIT  = 3'd3,
        CC_DOT    = 3'd4,
        CC_BAD    = 3'd5
    } cclass_t;

    typedef struct packed {
        logic       op;
        logic [7:0] char_code;
    } char_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] tok_start;
        logic [15:0] tok_end;
        logic        last_of_item;
    } tok_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] tok_start;
        logic [15:0] tok_end;
    } tok_t;

    // All tokens caused by one request; tok_b is used only when two is set
    typedef struct packed {
        logic two;
        tok_t tok_a;
        tok_t tok_b;
    } pair_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    // Priority order matters: x and X classify as single-character tokens
    function automatic cclass_t char_class(input logic [7:0] c);
        cclass_t cc;
        case (c) inside
            8'h20, [8'h09:8'h0D]:                   cc = CC_SPACE;
            8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2A,
            8'h2F, 8'h27, 8'h5E, 8'h78, 8'h58:      cc = CC_SINGLE;
            [8'h41:8'h5A], [8'h61:8'h7A]:           cc = CC_ALPHA;
            [8'h30:8'h39]:                          cc = CC_DIGIT;
            8'h2E:                                  cc = CC_DOT;
            default:                                cc = CC_BAD;
        endcase
        return cc;
    endfunction

    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        unique case (c) inside
            8'h28:        k = K_LPAREN;
            8'h29:        k = K_RPAREN;
            8'h2B:        k = K_PLUS;
            8'h2D:        k = K_MINUS;
            8'h2A:        k = K_STAR;
            8'h2F:        k = K_SLASH;
            8'h27:        k = K_QUOTE;
            8'h5E:        k = K_CARET;
            8'h78, 8'h58: k = K_X;
            default:      k = K_BAD;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- design/calculator_expression_lexer.sv -----
// Expression lexer: cuts a stream of characters into tokens.
//
// Request channel (char_valid / char_ready / char_item): one character per
// request, or an end-of-input marker (op set). Token channel (tok_valid /
// tok_ready / tok_item): kind, start and end positions, and last_of_item on
// the final token caused by a request. A request gives zero, one or two tokens.
//
// The front part takes a request every cycle it has queue room, updates the
// run state at once and pushes the request's tokens as one entry into a
// four-entry queue. The back part holds one entry in its output slot and
// sends its tokens one per cycle while tok_ready is high. The first token of
// a request is registered first in the queue and then in the output slot
// before it appears; a second token follows once the first is taken.
// Throughput is one request per cycle while requests give at most one token
// and tok_ready is high; two-token requests are limited by the one output port.
// When the receiver stalls, the slot holds its token and the queue fills;
// char_ready drops only when the queue is full. After an error the block
// keeps char_ready high and drops every request until reset.
// Reset (rst_n low, asynchronous) clears the run, position, error flag,
// queue and output slot; no token is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module calculator_expression_lexer (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  char_valid,
    output logic                 char_ready,
    input  clex_pkg::char_item_t char_item,
    output logic                 tok_valid,
    input  wire                  tok_ready,
    output clex_pkg::tok_item_t  tok_item
);
    import clex_pkg::*;

    logic  push;
    pair_t push_pair;
    logic  q_full;
    logic  q_empty;
    logic  pop;
    pair_t head;

    // Classify requests and track the open run
    clex_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .q_full     (q_full),
        .push       (push),
        .push_pair  (push_pair)
    );

    // Decouple classification from token delivery
    clex_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_pair (push_pair),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    // Deliver tokens one per cycle from the registered slot while tok_ready is high
    clex_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_item  (tok_item)
    );

endmodule

`default_nettype wire

// ----- design/clex_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clex_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  char_valid,
    output logic                 char_ready,
    input  clex_pkg::char_item_t char_item,
    input  wire                  q_full,
    output logic                 push,
    output clex_pkg::pair_t      push_pair
);
    import clex_pkg::*;

    mode_t       mode_reg,     mode_next;
    logic [15:0] begin_reg,    begin_next;
    logic [15:0] position_reg, position_next;
    logic        failed_reg,   failed_next;

    logic        accept;
    logic        close_v;
    logic        close_dot;
    logic        use_close;
    logic        char_v;
    tok_t        tok_close;
    tok_t        tok_char;
    cclass_t     cc;
    logic [15:0] pos_plus1;
    logic [15:0] begin_plus1;
    logic [7:0]  c;

    // Once failed, swallow requests without touching the queue
    assign char_ready  = failed_reg | ~q_full;
    assign accept      = char_valid & char_ready;
    assign c           = char_item.char_code;
    assign cc          = char_class(c);
    assign pos_plus1   = position_reg + 16'd1;
    assign begin_plus1 = begin_reg + 16'd1;

    // Token that closing the open run would give
    always_comb
    begin
        close_v   = 1'b0;
        close_dot = 1'b0;
        tok_close = '{kind: K_VAR, tok_start: begin_reg, tok_end: position_reg};
        unique case (mode_reg)
            MODE_IDLE: ;
            MODE_VAR:
            begin
                close_v = 1'b1;
            end
            MODE_NUM:
            begin
                close_v        = 1'b1;
                tok_close.kind = K_NUM;
            end
            MODE_DOT:
            begin
                close_v   = 1'b1;
                close_dot = 1'b1;
                tok_close = '{kind: K_DOT, tok_start: begin_reg, tok_end: begin_plus1};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        mode_next     = mode_reg;
        begin_next    = begin_reg;
        position_next = position_reg;
        failed_next   = failed_reg;
        use_close     = 1'b0;
        char_v        = 1'b0;
        tok_char      = '{kind: K_BAD, tok_start: position_reg, tok_end: position_reg};

        if (accept && !failed_reg)
        begin
            if (char_item.op)
            begin
                // end of input: flush the run and start over; a lone dot run sets the error flag
                use_close     = close_v;
                position_next = '0;
                mode_next     = MODE_IDLE;
                failed_next   = close_dot;
            end
            else if (position_reg >= POS_LIMIT)
            begin
                use_close   = close_v;
                mode_next   = MODE_IDLE;
                failed_next = 1'b1;
                if (!close_dot)
                begin
                    char_v        = 1'b1;
                    tok_char.kind = K_LONG;
                end
            end
            else
            begin
                position_next = pos_plus1;
                if (mode_reg == MODE_VAR && is_alpha(c))
                begin
                    // extend letter run
                end
                else if ((mode_reg == MODE_NUM || mode_reg == MODE_DOT) &&
                         (cc == CC_DIGIT || cc == CC_DOT))
                begin
                    mode_next = MODE_NUM;
                end
                else
                begin
                    use_close = close_v;
                    mode_next = MODE_IDLE;
                    if (close_dot)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        unique case (cc)
                            CC_SPACE: ;
                            CC_SINGLE:
                            begin
                                char_v   = 1'b1;
                                tok_char = '{kind: single_kind(c), tok_start: position_reg,
                                             tok_end: pos_plus1};
                            end
                            CC_ALPHA:
                            begin
                                mode_next  = MODE_VAR;
                                begin_next = position_reg;
                            end
                            CC_DIGIT:
                            begin
                                mode_next  = MODE_NUM;
                                begin_next = position_reg;
                            end
                            CC_DOT:
                            begin
                                mode_next  = MODE_DOT;
                                begin_next = position_reg;
                            end
                            default:
                            begin
                                char_v      = 1'b1;
                                failed_next = 1'b1;
                            end
                        endcase
                    end
                end
            end
        end
    end

    assign push            = use_close | char_v;
    assign push_pair.two   = use_close & char_v;
    assign push_pair.tok_a = use_close ? tok_close : tok_char;
    assign push_pair.tok_b = tok_char;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            begin_reg    <= '0;
            position_reg <= '0;
            failed_reg   <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            begin_reg    <= begin_next;
            position_reg <= position_next;
            failed_reg   <= failed_next;
        end
    end

    a_no_push_failed: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !failed_reg)
        else $error("token pushed after failure");

    a_failed_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && failed_reg) |=> ($stable(position_reg) && failed_reg))
        else $error("state moved while failed");

endmodule

`default_nettype wire

// ----- design/clex_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clex_queue (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  clex_pkg::pair_t  push_pair,
    output logic             full,
    input  wire              pop,
    output clex_pkg::pair_t  head,
    output logic             empty
);
    import clex_pkg::*;

    pair_t          mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg,  count_next;

    assign full  = (count_reg == (QAW+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");

endmodule

`default_nettype wire

// ----- design/clex_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clex_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  clex_pkg::pair_t      head,
    input  wire                  empty,
    output logic                 pop,
    output logic                 tok_valid,
    input  wire                  tok_ready,
    output clex_pkg::tok_item_t  tok_item
);
    import clex_pkg::*;

    pair_t slot_reg,       slot_next;
    logic  slot_valid_reg, slot_valid_next;
    logic  sel_reg,        sel_next;

    tok_t  cur;
    logic  last;
    logic  load;

    assign cur       = sel_reg ? slot_reg.tok_b : slot_reg.tok_a;
    assign last      = sel_reg | ~slot_reg.two;
    assign tok_valid = slot_valid_reg;

    assign tok_item.kind         = cur.kind;
    assign tok_item.tok_start    = cur.tok_start;
    assign tok_item.tok_end      = cur.tok_end;
    assign tok_item.last_of_item = last;

    // Refill when the slot is empty or its final token leaves this cycle
    assign load = ~slot_valid_reg | (tok_ready & last);
    assign pop  = load & ~empty;

    always_comb
    begin
        slot_next       = slot_reg;
        slot_valid_next = slot_valid_reg;
        sel_next        = sel_reg;
        if (load)
        begin
            slot_next       = head;
            slot_valid_next = ~empty;
            sel_next        = 1'b0;
        end
        else if (tok_ready)
        begin
            sel_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            sel_reg        <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            sel_reg        <= sel_next;
        end
    end

    a_sel_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_valid_reg && sel_reg) |-> slot_reg.two)
        else $error("second token selected for single-token slot");

endmodule

`default_nettype wire
